// ===== hdl/mcadc_pkg.sv =====
// Shared types, codes and constants of the multichannel ADC moving average block.
`default_nettype none
package mcadc_pkg;

   // Ring depth used when the top level is not given another value.
   localparam int RING_DEPTH_DEFAULT = 8;

   // Entries of the queue between the front and the back end.
   localparam int QUEUE_DEPTH = 2;

   // Channel codes.
   localparam logic [1:0] CH_GEAR    = 2'd0;
   localparam logic [1:0] CH_BATTERY = 2'd1;
   localparam logic [1:0] CH_TEMP    = 2'd2;
   localparam int NUM_CHANNELS = 3;

   // Configuration register indexes.
   localparam logic [1:0] CSR_GEAR_MIN_LEVEL = 2'd0;
   localparam logic [1:0] CSR_SETTLE_DISCARD = 2'd1;
   localparam logic [1:0] CSR_DWELL_LIMIT    = 2'd2;

   // Configuration reset values.
   localparam logic [7:0] GEAR_MIN_LEVEL_RESET = 8'd10;
   localparam logic [2:0] SETTLE_DISCARD_RESET = 3'd2;
   localparam logic [5:0] DWELL_LIMIT_RESET    = 6'd10;

   // Battery scaling: floor(avg * 1881 / 2560) = floor(floor(avg * 1881 / 512) / 5).
   localparam logic [10:0] BATT_GAIN   = 11'd1881;
   localparam int          BATT_SHIFT  = 9;
   localparam logic [7:0]  DIV5_RECIP  = 8'd205;
   localparam int          DIV5_SHIFT  = 10;
   localparam logic [7:0]  VOLT_MIN    = 8'd100;
   localparam logic [7:0]  VOLT_MAX    = 8'd199;

   // Temperature scaling: trunc((avg * 165 - 6400) / 128).
   localparam logic signed [17:0] TEMP_GAIN   = 18'sd165;
   localparam logic signed [17:0] TEMP_OFFSET = 18'sd6400;
   localparam logic signed [17:0] TEMP_ROUND  = 18'sd127;
   localparam int                 TEMP_SHIFT  = 7;
   localparam logic signed [17:0] TEMP_MIN    = -18'sd40;
   localparam logic signed [17:0] TEMP_MAX    = 18'sd60;

   // One classified conversion, as it travels from the front to the back end.
   typedef struct packed {
      logic [1:0] channel;
      logic       stored;
      logic [7:0] sample;
   } item_type;

   // One finished result.
   typedef struct packed {
      logic [1:0]        channel;
      logic              stored;
      logic [7:0]        gear_average;
      logic [7:0]        battery_average;
      logic [7:0]        temp_average;
      logic [7:0]        battery_tenths_volt;
      logic signed [6:0] temp_celsius;
   } result_type;

endpackage
`default_nettype wire

// ===== hdl/mcadc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module mcadc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]              rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== hdl/mcadc_front.sv =====
// Front end: configuration registers, channel rotation and sample classification.
`default_nettype none
module mcadc_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [7:0]        req_sample,
   input  wire logic              csr_wr_en,
   input  wire logic [1:0]        csr_index,
   input  wire logic [7:0]        csr_wr_data,
   input  wire logic              queue_ready,
   output logic                   queue_push,
   output mcadc_pkg::item_type    queue_item
);

   logic [7:0] gear_min_level_ff, gear_min_level_in;
   logic [2:0] settle_discard_ff, settle_discard_in;
   logic [5:0] dwell_limit_ff, dwell_limit_in;
   logic [1:0] channel_ff, channel_in;
   logic [5:0] dwell_ff, dwell_in;
   logic [5:0] dwell_next;
   logic [1:0] channel_next;
   logic       accept;
   logic       settled;
   logic       stored;

   // Configuration writes; an index past the register list is ignored.
   always_comb begin
      gear_min_level_in = gear_min_level_ff;
      settle_discard_in = settle_discard_ff;
      dwell_limit_in    = dwell_limit_ff;
      if (csr_wr_en) begin
         case (csr_index)
            mcadc_pkg::CSR_GEAR_MIN_LEVEL: gear_min_level_in = csr_wr_data;
            mcadc_pkg::CSR_SETTLE_DISCARD: settle_discard_in = csr_wr_data[2:0];
            mcadc_pkg::CSR_DWELL_LIMIT:    dwell_limit_in    = csr_wr_data[5:0];
            default: ;
         endcase
      end
   end

   assign req_ready = queue_ready;
   assign accept    = req_valid && queue_ready;

   // Dwell count advances on every conversion; the first few after a switch settle.
   assign dwell_next = dwell_ff + 6'd1;
   assign settled    = dwell_next > {3'd0, settle_discard_ff};

   always_comb begin
      case (channel_ff)
         mcadc_pkg::CH_GEAR:    channel_next = mcadc_pkg::CH_BATTERY;
         mcadc_pkg::CH_BATTERY: channel_next = mcadc_pkg::CH_TEMP;
         default:               channel_next = mcadc_pkg::CH_GEAR;
      endcase
   end

   // Gear samples must clear the threshold; an unused channel code stores nothing.
   always_comb begin
      case (channel_ff)
         mcadc_pkg::CH_GEAR:    stored = settled && (req_sample > gear_min_level_ff);
         mcadc_pkg::CH_BATTERY: stored = settled;
         mcadc_pkg::CH_TEMP:    stored = settled;
         default:               stored = 1'b0;
      endcase
   end

   // Channel switch once the dwell count passes its limit.
   always_comb begin
      channel_in = channel_ff;
      dwell_in   = dwell_ff;
      if (accept) begin
         dwell_in = dwell_next;
         if (settled && (dwell_next > dwell_limit_ff)) begin
            channel_in = channel_next;
            dwell_in   = 6'd0;
         end
      end
   end

   assign queue_push         = accept;
   assign queue_item.channel = channel_ff;
   assign queue_item.stored  = stored;
   assign queue_item.sample  = req_sample;

   always_ff @(posedge clock) begin
      if (reset) begin
         gear_min_level_ff <= mcadc_pkg::GEAR_MIN_LEVEL_RESET;
         settle_discard_ff <= mcadc_pkg::SETTLE_DISCARD_RESET;
         dwell_limit_ff    <= mcadc_pkg::DWELL_LIMIT_RESET;
         channel_ff        <= mcadc_pkg::CH_GEAR;
         dwell_ff          <= 6'd0;
      end else begin
         gear_min_level_ff <= gear_min_level_in;
         settle_discard_ff <= settle_discard_in;
         dwell_limit_ff    <= dwell_limit_in;
         channel_ff        <= channel_in;
         dwell_ff          <= dwell_in;
      end
   end

endmodule
`default_nettype wire

// ===== hdl/mcadc_fifo.sv =====
// Short queue of classified conversions between the front and the back end.
`default_nettype none
module mcadc_fifo (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire mcadc_pkg::item_type   push_item,
   output logic                       push_ready,
   input  wire logic                  pop,
   output logic                       pop_valid,
   output mcadc_pkg::item_type        pop_item
);

   localparam int PtrW   = $clog2(mcadc_pkg::QUEUE_DEPTH);
   localparam int CountW = $clog2(mcadc_pkg::QUEUE_DEPTH + 1);
   localparam logic [PtrW-1:0]   LastPtr = PtrW'(mcadc_pkg::QUEUE_DEPTH - 1);
   localparam logic [CountW-1:0] FullCount = CountW'(mcadc_pkg::QUEUE_DEPTH);

   mcadc_pkg::item_type entry_ff [mcadc_pkg::QUEUE_DEPTH];
   logic [PtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CountW-1:0] count_ff, count_in;
   logic              do_push;
   logic              do_pop;

   assign push_ready = count_ff != FullCount;
   assign pop_valid  = count_ff != '0;
   assign pop_item   = entry_ff[rd_ptr_ff];
   assign do_push    = push && push_ready;
   assign do_pop     = pop && pop_valid;

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
`default_nettype wire

// ===== hdl/mcadc_back.sv =====
// Back end: per-channel rings with running sums, averages and unit scaling.
`default_nettype none
module mcadc_back #(
   parameter int RING_DEPTH = mcadc_pkg::RING_DEPTH_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  item_valid,
   input  wire mcadc_pkg::item_type   item,
   output logic                       item_pop,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output mcadc_pkg::result_type      rsp_result
);

   localparam int NumCh  = mcadc_pkg::NUM_CHANNELS;
   localparam int SlotW  = $clog2(RING_DEPTH);
   localparam int FillW  = $clog2(RING_DEPTH + 1);
   localparam int SumW   = 8 + SlotW;
   localparam int Shift  = SumW + SlotW;
   localparam int RecipW = SumW + 1;
   localparam int ProdW  = SumW + RecipW;
   localparam int Recip  = ((1 << Shift) + RING_DEPTH - 1) / RING_DEPTH;
   localparam logic [RecipW-1:0] RecipConst = RecipW'(Recip);
   localparam logic [SlotW-1:0]  LastSlot   = SlotW'(RING_DEPTH - 1);
   localparam logic [FillW-1:0]  FullCount  = FillW'(RING_DEPTH);

   logic advance;

   // Ring state per channel.
   logic [SlotW-1:0] slot_ff [NumCh];
   logic [FillW-1:0] fill_ff [NumCh];
   logic [SumW-1:0]  sum_ff  [NumCh];

   // Pipeline registers: s1 ring update, s2 reciprocal product, s3 averages,
   // s4 scaling products, s5 output.
   logic       s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff, s5_valid_ff;
   logic [1:0] s1_ch_ff, s2_ch_ff, s3_ch_ff, s4_ch_ff;
   logic       s1_st_ff, s2_st_ff, s3_st_ff, s4_st_ff;
   logic [ProdW-1:0] s2_prod_ff [NumCh];
   logic             s2_full_ff [NumCh];
   logic [7:0]       s3_avg_ff  [NumCh];
   logic [7:0]       s4_avg_ff  [NumCh];
   logic [9:0]              s4_volt_ff;
   logic signed [17:0]      s4_temp_ff;
   mcadc_pkg::result_type   s5_result_ff, s5_result_in;

   // The whole pipeline moves unless the output holds a result not yet taken.
   assign advance  = !s5_valid_ff || rsp_ready;
   assign item_pop = advance && item_valid;

   // Rings: the RAM read port always presents the entry at the current slot.
   for (genvar c = 0; c < NumCh; c++) begin : g_ring
      logic             wr_en;
      logic [SlotW-1:0] slot_in;
      logic [FillW-1:0] fill_in;
      logic [SumW-1:0]  sum_in;
      logic [7:0]       old_value;
      logic [7:0]       rd_data;

      assign wr_en     = item_pop && item.stored && (item.channel == 2'(c));
      assign old_value = (fill_ff[c] == FullCount) ? rd_data : 8'd0;

      always_comb begin
         slot_in = slot_ff[c];
         fill_in = fill_ff[c];
         sum_in  = sum_ff[c];
         if (wr_en) begin
            slot_in = (slot_ff[c] == LastSlot) ? '0 : slot_ff[c] + 1'b1;
            if (fill_ff[c] != FullCount) begin
               fill_in = fill_ff[c] + 1'b1;
            end
            sum_in = sum_ff[c] - SumW'(old_value) + SumW'(item.sample);
         end
      end

      mcadc_ram #(
         .WIDTH(8),
         .DEPTH(RING_DEPTH)
      ) u_ram (
         .clock   (clock),
         .wr_en   (wr_en),
         .wr_addr (slot_ff[c]),
         .wr_data (item.sample),
         .rd_addr (slot_in),
         .rd_data (rd_data)
      );

      always_ff @(posedge clock) begin
         if (reset) begin
            slot_ff[c] <= '0;
            fill_ff[c] <= '0;
            sum_ff[c]  <= '0;
         end else begin
            slot_ff[c] <= slot_in;
            fill_ff[c] <= fill_in;
            sum_ff[c]  <= sum_in;
         end
      end

      // Sum divided by the depth through a reciprocal product.
      always_ff @(posedge clock) begin
         if (advance) begin
            s2_prod_ff[c] <= ProdW'(sum_ff[c]) * ProdW'(RecipConst);
            s2_full_ff[c] <= fill_ff[c] == FullCount;
            s3_avg_ff[c]  <= s2_full_ff[c] ? s2_prod_ff[c][Shift +: 8] : 8'd0;
            s4_avg_ff[c]  <= s3_avg_ff[c];
         end
      end
   end

   // Scaling products for battery and temperature.
   logic [18:0]        volt_prod;
   logic signed [17:0] temp_avg_s;
   logic signed [17:0] temp_lin;

   assign volt_prod  = 19'(s3_avg_ff[mcadc_pkg::CH_BATTERY]) * 19'(mcadc_pkg::BATT_GAIN);
   assign temp_avg_s = signed'({10'd0, s3_avg_ff[mcadc_pkg::CH_TEMP]});
   assign temp_lin   = temp_avg_s * mcadc_pkg::TEMP_GAIN - mcadc_pkg::TEMP_OFFSET;

   always_ff @(posedge clock) begin
      if (advance) begin
         s4_volt_ff <= volt_prod[mcadc_pkg::BATT_SHIFT +: 10];
         s4_temp_ff <= temp_lin;
      end
   end

   // Final divide by five, truncating divide by 128, and clamping.
   logic [17:0]        div5_prod;
   logic [7:0]         volt_q;
   logic signed [17:0] temp_div;

   assign div5_prod = 18'(s4_volt_ff) * 18'(mcadc_pkg::DIV5_RECIP);
   assign volt_q    = div5_prod[mcadc_pkg::DIV5_SHIFT +: 8];
   assign temp_div  = (s4_temp_ff < 0) ?
                      ((s4_temp_ff + mcadc_pkg::TEMP_ROUND) >>> mcadc_pkg::TEMP_SHIFT) :
                      (s4_temp_ff >>> mcadc_pkg::TEMP_SHIFT);

   always_comb begin
      s5_result_in.channel         = s4_ch_ff;
      s5_result_in.stored          = s4_st_ff;
      s5_result_in.gear_average    = s4_avg_ff[mcadc_pkg::CH_GEAR];
      s5_result_in.battery_average = s4_avg_ff[mcadc_pkg::CH_BATTERY];
      s5_result_in.temp_average    = s4_avg_ff[mcadc_pkg::CH_TEMP];
      if (volt_q < mcadc_pkg::VOLT_MIN) begin
         s5_result_in.battery_tenths_volt = mcadc_pkg::VOLT_MIN;
      end else if (volt_q > mcadc_pkg::VOLT_MAX) begin
         s5_result_in.battery_tenths_volt = mcadc_pkg::VOLT_MAX;
      end else begin
         s5_result_in.battery_tenths_volt = volt_q;
      end
      if (temp_div < mcadc_pkg::TEMP_MIN) begin
         s5_result_in.temp_celsius = 7'(mcadc_pkg::TEMP_MIN);
      end else if (temp_div > mcadc_pkg::TEMP_MAX) begin
         s5_result_in.temp_celsius = 7'(mcadc_pkg::TEMP_MAX);
      end else begin
         s5_result_in.temp_celsius = 7'(temp_div);
      end
   end

   // Item tags and the output register.
   always_ff @(posedge clock) begin
      if (advance) begin
         s1_ch_ff     <= item.channel;
         s1_st_ff     <= item.stored;
         s2_ch_ff     <= s1_ch_ff;
         s2_st_ff     <= s1_st_ff;
         s3_ch_ff     <= s2_ch_ff;
         s3_st_ff     <= s2_st_ff;
         s4_ch_ff     <= s3_ch_ff;
         s4_st_ff     <= s3_st_ff;
         s5_result_ff <= s5_result_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= item_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
         s5_valid_ff <= s4_valid_ff;
      end
   end

   assign rsp_valid  = s5_valid_ff;
   assign rsp_result = s5_result_ff;

endmodule
`default_nettype wire

// ===== hdl/multichannel_adc_moving_average.sv =====
// Top level of the multichannel ADC moving average block.
//
// Input channel (req_): one 8-bit conversion per transfer. The block rotates
// among gear, battery and temperature, drops the settling conversions after
// each switch, and stores the rest (gear only above its threshold) in its ring.
// Result channel (rsp_): one result per input transfer, in order: the channel
// and stored flag on tuser, the three ring averages and the scaled battery
// voltage and temperature on tdata.
// Configuration port (csr_): a write with csr_wr_en high sets register
// csr_index (0 gear threshold, 1 settle discard, 2 dwell limit).
// A result passes from its input transfer through the queue, ring update,
// reciprocal product, averages, scaling products and output register.
// Throughput: one item per cycle while the receiver takes results; each ring
// update takes one RAM read and write per cycle.
// Reset clears the rings (through their fill counts), sums, channel and dwell
// count and loads the register reset values; no result is pending afterward.
// When the receiver stalls, the output register holds its result, the
// pipeline halts and a two-entry queue absorbs new transfers; req_tready
// drops only when that queue is full.
`default_nettype none
module multichannel_adc_moving_average #(
   parameter int RING_DEPTH = mcadc_pkg::RING_DEPTH_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] adc_sample
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata,   // [7:0] gear_average, [15:8] battery_average,
                                         // [23:16] temp_average,
                                         // [31:24] battery_tenths_volt,
                                         // [38:32] temp_celsius, [39] zero
   output logic [2:0]       rsp_tuser,   // [1:0] sampled_channel, [2] sample_stored
   input  wire logic        csr_wr_en,
   input  wire logic [1:0]  csr_index,
   input  wire logic [7:0]  csr_wr_data
);

   logic                  queue_push;
   logic                  queue_ready;
   mcadc_pkg::item_type   push_item;
   logic                  queue_valid;
   logic                  queue_pop;
   mcadc_pkg::item_type   pop_item;
   mcadc_pkg::result_type result;

   mcadc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_sample  (req_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .queue_ready (queue_ready),
      .queue_push  (queue_push),
      .queue_item  (push_item)
   );

   mcadc_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (queue_push),
      .push_item  (push_item),
      .push_ready (queue_ready),
      .pop        (queue_pop),
      .pop_valid  (queue_valid),
      .pop_item   (pop_item)
   );

   mcadc_back #(
      .RING_DEPTH(RING_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (queue_valid),
      .item       (pop_item),
      .item_pop   (queue_pop),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_result (result)
   );

   // Result packing onto the stream.
   assign rsp_tuser = {result.stored, result.channel};
   assign rsp_tdata = {1'b0, result.temp_celsius, result.battery_tenths_volt,
                       result.temp_average, result.battery_average, result.gear_average};

endmodule
`default_nettype wire

// ===== hdl/mcadc_checker.sv =====
// Port-level checks of the multichannel ADC moving average block and their binding.
`default_nettype none
module mcadc_port_checks (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [39:0] rsp_tdata,
   input wire logic [2:0]  rsp_tuser
);

   // A stalled result keeps its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // Reset leaves no result pending.
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result pending after reset");

   // Scaled outputs stay inside their clamp ranges.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[31:24] >= 8'd100 && rsp_tdata[31:24] <= 8'd199 &&
                     $signed(rsp_tdata[38:32]) >= -7'sd40 &&
                     $signed(rsp_tdata[38:32]) <= 7'sd60)
      else $error("scaled output out of range");

   // An empty or unfilled temperature ring reads as the lowest temperature.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[23:16] == 8'd0 |-> rsp_tdata[38:32] == 7'h58)
      else $error("zero temperature average not at lower clamp");

   // Only the three real channel codes are reported.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser[1:0] <= mcadc_pkg::CH_TEMP)
      else $error("unused channel code reported");

endmodule

bind multichannel_adc_moving_average mcadc_port_checks u_checker (.*);
`default_nettype wire
